// File: rtl/wsdc_pkg.sv
// ---------------------------------------------------------------------------
// Wrench slew damp clamp package
// Shared types, register indexes, reset values and sequencer states.
// ---------------------------------------------------------------------------
package wsdc_pkg;

    localparam int FRAC_BITS_DEF = 12;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DAMP_LIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMP_ANG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_F    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_T    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_F     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_T     = 3'd5;

    localparam logic [15:0] RST_DAMP_LIN = 16'd1434;
    localparam logic [15:0] RST_DAMP_ANG = 16'd102;
    localparam logic [14:0] RST_STEP_F   = 15'd273;
    localparam logic [14:0] RST_STEP_T   = 15'd164;
    localparam logic [14:0] RST_MAX_F    = 15'd20480;
    localparam logic [14:0] RST_MAX_T    = 15'd2048;

    typedef struct packed {
        logic signed [15:0] target_force_x;
        logic signed [15:0] target_force_y;
        logic signed [15:0] target_force_z;
        logic signed [15:0] target_torque_x;
        logic signed [15:0] target_torque_y;
        logic signed [15:0] target_torque_z;
        logic signed [15:0] speed_x;
        logic signed [15:0] speed_y;
        logic signed [15:0] speed_z;
        logic signed [15:0] spin_x;
        logic signed [15:0] spin_y;
        logic signed [15:0] spin_z;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] out_force_x;
        logic signed [15:0] out_force_y;
        logic signed [15:0] out_force_z;
        logic signed [15:0] out_torque_x;
        logic signed [15:0] out_torque_y;
        logic signed [15:0] out_torque_z;
    } out_item_t;

    typedef struct packed {
        logic [15:0] damp_lin;
        logic [15:0] damp_ang;
        logic [14:0] step_f;
        logic [14:0] step_t;
        logic [14:0] max_f;
        logic [14:0] max_t;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQ,
        ST_SQRT,
        ST_CHK,
        ST_SCMUL,
        ST_DIV,
        ST_UPD,
        ST_DMUL,
        ST_DONE,
        ST_OUT
    } state_t;

    // Control from the sequencer to the divide/root unit.
    typedef struct packed {
        logic sqrt_start;
        logic div_start;
    } iter_ctl_t;

endpackage

// File: rtl/wrench_slew_damp_clamp_top.sv
// ---------------------------------------------------------------------------
// Wrench slew damp clamp top level
// Slew-limits the applied force and torque vectors, subtracts damping and
// clamps each axis, using one shared multiplier and one iterative unit.
//
// Channel   Signals                       Payload
// in        in_valid / in_ready           wsdc_pkg::in_item_t
// out       out_valid / out_ready         wsdc_pkg::out_item_t
// cfg       cfg_we / cfg_index / cfg_data six registers
//
// The work per item is the 18-step square root run once per vector and the
// 36-step divider run once per axis of a vector that needs scaling.
// Reset clears the applied wrench and loads the register defaults.
// The block takes no new transfer until the result has been taken.
// ---------------------------------------------------------------------------
module wrench_slew_damp_clamp_top
#(
    parameter int FRAC_BITS = wsdc_pkg::FRAC_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  wsdc_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output wsdc_pkg::out_item_t              out_data,
    input  logic                             cfg_we,
    input  logic [wsdc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wsdc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    wsdc_pkg::cfg_t      cfg;
    wsdc_pkg::iter_ctl_t ictl;
    wsdc_pkg::state_t    state_reg, state_next;

    logic signed [15:0] app_reg [6];
    logic signed [15:0] tgt_reg [6];
    logic signed [15:0] vel_reg [6];
    logic signed [16:0] d_reg [3];
    logic [35:0]        sum_reg;
    logic [35:0]        mag_reg;
    logic [31:0]        num_reg;
    logic signed [15:0] res_reg [6];
    logic               vec_reg;
    logic [1:0]         ax_reg;
    logic [2:0]         ix_reg;
    logic               started_reg;

    logic [35:0] it_result;
    logic        it_busy;
    logic [35:0] it_operand;

    logic [14:0]        step;
    logic [16:0]        dabs;
    logic [2:0]         base;
    logic [2:0]         ai;
    logic [16:0]        mul_a;
    logic [16:0]        mul_b;
    logic [33:0]        mul_p;
    logic signed [16:0] vsel;
    logic [15:0]        vabs;
    logic [15:0]        gain;
    logic [31:0]        dprod;
    logic signed [32:0] dterm;
    logic signed [33:0] total;
    logic signed [33:0] lim;

    wsdc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign it_operand = (state_reg == wsdc_pkg::ST_DIV) ? {4'd0, num_reg} : sum_reg;

    wsdc_iter u_iter
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ictl),
        .operand (it_operand),
        .divisor (mag_reg[17:0]),
        .result  (it_result),
        .busy    (it_busy)
    );

    assign base = vec_reg ? 3'd3 : 3'd0;
    assign ai   = base + {1'b0, ax_reg};
    assign step = vec_reg ? cfg.step_t : cfg.step_f;
    assign dabs = d_reg[ax_reg][16] ? 17'(-d_reg[ax_reg]) : 17'(d_reg[ax_reg]);

    // One shared multiplier: squares, step scaling and damping.
    always_comb
    begin
        mul_a = dabs;
        mul_b = dabs;
        vsel  = {vel_reg[ix_reg][15], vel_reg[ix_reg]};
        vabs  = vsel[16] ? 16'(-vsel) : vsel[15:0];
        gain  = (ix_reg < 3'd3) ? cfg.damp_lin : cfg.damp_ang;
        case (state_reg)
            wsdc_pkg::ST_SCMUL: mul_b = {2'b00, step};
            wsdc_pkg::ST_DMUL:
            begin
                mul_a = {1'b0, gain};
                mul_b = {1'b0, vabs};
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        dprod = mul_p[31:0] >> FRAC_BITS;
        dterm = vsel[16] ? -$signed({1'b0, dprod}) : $signed({1'b0, dprod});
        total = 34'(app_reg[ix_reg]) - 34'(dterm);
        lim   = (ix_reg < 3'd3) ? $signed({19'd0, cfg.max_f}) : $signed({19'd0, cfg.max_t});
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wsdc_pkg::ST_IDLE:  if (in_valid) state_next = wsdc_pkg::ST_DIFF;
            wsdc_pkg::ST_DIFF:  state_next = wsdc_pkg::ST_SQ;
            wsdc_pkg::ST_SQ:    if (ax_reg == 2'd2) state_next = wsdc_pkg::ST_SQRT;
            wsdc_pkg::ST_SQRT:  if (started_reg && !it_busy) state_next = wsdc_pkg::ST_CHK;
            wsdc_pkg::ST_CHK:
            begin
                if (step != '0 && mag_reg > {21'd0, step})
                    state_next = wsdc_pkg::ST_SCMUL;
                else
                    state_next = wsdc_pkg::ST_UPD;
            end
            wsdc_pkg::ST_SCMUL: state_next = wsdc_pkg::ST_DIV;
            wsdc_pkg::ST_DIV:
            begin
                if (started_reg && !it_busy)
                    state_next = (ax_reg == 2'd2) ? wsdc_pkg::ST_UPD : wsdc_pkg::ST_SCMUL;
            end
            wsdc_pkg::ST_UPD:
                state_next = vec_reg ? wsdc_pkg::ST_DMUL : wsdc_pkg::ST_DIFF;
            wsdc_pkg::ST_DMUL:  if (ix_reg == 3'd5) state_next = wsdc_pkg::ST_DONE;
            wsdc_pkg::ST_DONE:  state_next = wsdc_pkg::ST_OUT;
            wsdc_pkg::ST_OUT:   if (out_ready) state_next = wsdc_pkg::ST_IDLE;
            default:            state_next = wsdc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready        = (state_reg == wsdc_pkg::ST_IDLE);
        out_valid       = (state_reg == wsdc_pkg::ST_OUT);
        ictl.sqrt_start = (state_reg == wsdc_pkg::ST_SQRT) && !started_reg;
        ictl.div_start  = (state_reg == wsdc_pkg::ST_DIV) && !started_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= wsdc_pkg::ST_IDLE;
            started_reg <= 1'b0;
            vec_reg     <= 1'b0;
            ax_reg      <= '0;
            ix_reg      <= '0;
            for (int i = 0; i < 6; i++)
            begin
                app_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                wsdc_pkg::ST_IDLE:
                begin
                    vec_reg <= 1'b0;
                    ax_reg  <= '0;
                    ix_reg  <= '0;
                end
                wsdc_pkg::ST_SQ:
                    ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                wsdc_pkg::ST_SQRT:
                    started_reg <= it_busy ? 1'b1 : !started_reg;
                wsdc_pkg::ST_DIV:
                begin
                    if (!started_reg)
                        started_reg <= 1'b1;
                    else if (!it_busy)
                    begin
                        started_reg <= 1'b0;
                        ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                    end
                end
                wsdc_pkg::ST_CHK:
                    started_reg <= 1'b0;
                wsdc_pkg::ST_UPD:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        app_reg[base + 3'(i)] <= 16'(app_reg[base + 3'(i)] + d_reg[i]);
                    end
                    vec_reg <= 1'b1;
                    ax_reg  <= '0;
                end
                wsdc_pkg::ST_DMUL:
                    ix_reg <= (ix_reg == 3'd5) ? 3'd0 : ix_reg + 3'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            wsdc_pkg::ST_IDLE:
            begin
                tgt_reg[0] <= in_data.target_force_x;
                tgt_reg[1] <= in_data.target_force_y;
                tgt_reg[2] <= in_data.target_force_z;
                tgt_reg[3] <= in_data.target_torque_x;
                tgt_reg[4] <= in_data.target_torque_y;
                tgt_reg[5] <= in_data.target_torque_z;
                vel_reg[0] <= in_data.speed_x;
                vel_reg[1] <= in_data.speed_y;
                vel_reg[2] <= in_data.speed_z;
                vel_reg[3] <= in_data.spin_x;
                vel_reg[4] <= in_data.spin_y;
                vel_reg[5] <= in_data.spin_z;
            end
            wsdc_pkg::ST_DIFF:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    d_reg[i] <= 17'(tgt_reg[base + 3'(i)]) - 17'(app_reg[base + 3'(i)]);
                end
                sum_reg <= '0;
            end
            wsdc_pkg::ST_SQ:
                sum_reg <= sum_reg + {2'b00, mul_p};
            wsdc_pkg::ST_SQRT:
                if (started_reg && !it_busy) mag_reg <= it_result;
            wsdc_pkg::ST_SCMUL:
                num_reg <= mul_p[31:0];
            wsdc_pkg::ST_DIV:
            begin
                if (started_reg && !it_busy)
                    d_reg[ax_reg] <= d_reg[ax_reg][16] ? 17'(-it_result[16:0])
                                                       : it_result[16:0];
            end
            wsdc_pkg::ST_DMUL:
            begin
                if (total > lim)
                    res_reg[ix_reg] <= lim[15:0];
                else if (total < -lim)
                    res_reg[ix_reg] <= 16'(-lim);
                else
                    res_reg[ix_reg] <= total[15:0];
            end
            default: ;
        endcase
    end

    assign out_data.out_force_x  = res_reg[0];
    assign out_data.out_force_y  = res_reg[1];
    assign out_data.out_force_z  = res_reg[2];
    assign out_data.out_torque_x = res_reg[3];
    assign out_data.out_torque_y = res_reg[4];
    assign out_data.out_torque_z = res_reg[5];

endmodule

// File: rtl/wsdc_cfg.sv
// ---------------------------------------------------------------------------
// Wrench slew damp clamp configuration registers
// Holds the six gain, step and limit registers written through the port.
// ---------------------------------------------------------------------------
module wsdc_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wsdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wsdc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output wsdc_pkg::cfg_t                      cfg
);

    wsdc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.damp_lin <= wsdc_pkg::RST_DAMP_LIN;
            cfg_reg.damp_ang <= wsdc_pkg::RST_DAMP_ANG;
            cfg_reg.step_f   <= wsdc_pkg::RST_STEP_F;
            cfg_reg.step_t   <= wsdc_pkg::RST_STEP_T;
            cfg_reg.max_f    <= wsdc_pkg::RST_MAX_F;
            cfg_reg.max_t    <= wsdc_pkg::RST_MAX_T;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wsdc_pkg::REG_DAMP_LIN: cfg_reg.damp_lin <= cfg_data;
                wsdc_pkg::REG_DAMP_ANG: cfg_reg.damp_ang <= cfg_data;
                wsdc_pkg::REG_STEP_F:   cfg_reg.step_f   <= cfg_data[14:0];
                wsdc_pkg::REG_STEP_T:   cfg_reg.step_t   <= cfg_data[14:0];
                wsdc_pkg::REG_MAX_F:    cfg_reg.max_f    <= cfg_data[14:0];
                wsdc_pkg::REG_MAX_T:    cfg_reg.max_t    <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/wsdc_iter.sv
// ---------------------------------------------------------------------------
// Wrench slew damp clamp iterative unit
// Shared bit-serial square root and restoring divider, one bit a cycle.
// ---------------------------------------------------------------------------
module wsdc_iter
(
    input  logic                clk,
    input  logic                rst_n,
    input  wsdc_pkg::iter_ctl_t ctl,
    input  logic [35:0]         operand,
    input  logic [17:0]         divisor,
    output logic [35:0]         result,
    output logic                busy
);

    logic [35:0] acc_reg, acc_next;
    logic [37:0] rem_reg, rem_next;
    logic [35:0] root_reg, root_next;
    logic [17:0] div_reg, div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        mode_reg, mode_next;
    logic        busy_reg, busy_next;

    logic [37:0] trial;
    logic [37:0] rem_sh;

    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        mode_next = mode_reg;
        busy_next = busy_reg;
        trial     = '0;
        rem_sh    = '0;
        if (ctl.sqrt_start)
        begin
            acc_next  = operand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 6'd18;
            mode_next = 1'b0;
            busy_next = 1'b1;
        end
        else if (ctl.div_start)
        begin
            acc_next  = operand;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = 6'd36;
            mode_next = 1'b1;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!mode_reg)
            begin
                rem_sh = {rem_reg[35:0], acc_reg[35:34]};
                trial  = {root_reg[35:0], 2'b01};
                acc_next = {acc_reg[33:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[34:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[34:0], 1'b0};
                end
            end
            else
            begin
                rem_sh = {rem_reg[36:0], acc_reg[35]};
                trial  = {20'd0, div_reg};
                if (rem_sh >= trial)
                begin
                    rem_next = rem_sh - trial;
                    acc_next = {acc_reg[34:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    acc_next = {acc_reg[34:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            mode_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        div_reg  <= div_next;
    end

    assign result = mode_reg ? acc_reg : root_reg;
    assign busy   = busy_reg;

endmodule

// File: test/wrench_slew_damp_clamp_top_tb.sv
// ---------------------------------------------------------------------------
// Wrench slew damp clamp testbench
// Drives force/torque targets and velocities through the valid/ready input,
// predicts each output wrench from a local model of the slew limiter, the
// damping and the clamp, and compares every output transfer field by field.
// Registers are rewritten between phases, with extremes among the settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module wrench_slew_damp_clamp_top_tb;

    localparam int N_RANDOM   = 1500;
    localparam int STALL_LIM  = 20000;
    localparam int DRAIN_WAIT = 400;

    localparam logic [wsdc_pkg::CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [wsdc_pkg::CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    typedef struct {
        wsdc_pkg::in_item_t  item;
        logic                known;
        wsdc_pkg::out_item_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    wsdc_pkg::in_item_t in_data;
    logic out_valid;
    logic out_ready;
    wsdc_pkg::out_item_t out_data;
    logic cfg_we;
    logic [wsdc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [wsdc_pkg::CFG_DATA_W-1:0] cfg_data;

    logic [15:0] gain_lin, gain_ang;
    logic [14:0] step_f, step_t, lim_f, lim_t;
    logic signed [15:0] wrench_now [6];

    wsdc_pkg::out_item_t wrench_queue [$];
    int fails;
    int sent_items;
    int got_items;
    int idle_count;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_recv;
    bit timed_out;

    wrench_slew_damp_clamp_top DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    function automatic longint floor_root(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void move_vector(int base, longint tgt [3], longint unsigned step);
        longint d [3];
        longint unsigned sum;
        longint unsigned mag;
        longint unsigned a;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = tgt[i] - longint'(wrench_now[base + i]);
            a = d[i] < 0 ? -d[i] : d[i];
            sum += a * a;
        end
        mag = floor_root(sum);
        if (step > 0 && mag > step)
            for (int i = 0; i < 3; i++)
            begin
                a = d[i] < 0 ? -d[i] : d[i];
                a = (a * step) / mag;
                d[i] = d[i] < 0 ? -longint'(a) : longint'(a);
            end
        for (int i = 0; i < 3; i++)
            wrench_now[base + i] = 16'(longint'(wrench_now[base + i]) + d[i]);
    endfunction

    function automatic logic signed [15:0] damp_clamp(logic signed [15:0] app,
        logic [15:0] gain, logic signed [15:0] vel, logic [14:0] lim);
        longint p;
        longint v;
        p = longint'(gain) * longint'(vel);
        p = p < 0 ? -((-p) >>> wsdc_pkg::FRAC_BITS_DEF) : (p >>> wsdc_pkg::FRAC_BITS_DEF);
        v = longint'(app) - p;
        if (v > longint'(lim))
            v = lim;
        if (v < -longint'(lim))
            v = -longint'(lim);
        return 16'(v);
    endfunction

    function automatic wsdc_pkg::out_item_t predict_wrench(wsdc_pkg::in_item_t it);
        longint tf [3];
        longint tt [3];
        wsdc_pkg::out_item_t r;
        tf = '{it.target_force_x, it.target_force_y, it.target_force_z};
        tt = '{it.target_torque_x, it.target_torque_y, it.target_torque_z};
        move_vector(0, tf, step_f);
        move_vector(3, tt, step_t);
        r.out_force_x  = damp_clamp(wrench_now[0], gain_lin, it.speed_x, lim_f);
        r.out_force_y  = damp_clamp(wrench_now[1], gain_lin, it.speed_y, lim_f);
        r.out_force_z  = damp_clamp(wrench_now[2], gain_lin, it.speed_z, lim_f);
        r.out_torque_x = damp_clamp(wrench_now[3], gain_ang, it.spin_x, lim_t);
        r.out_torque_y = damp_clamp(wrench_now[4], gain_ang, it.spin_y, lim_t);
        r.out_torque_z = damp_clamp(wrench_now[5], gain_ang, it.spin_z, lim_t);
        return r;
    endfunction

    // The write enable stays high; the caller drops it after the last write.
    task automatic write_reg(logic [wsdc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            wsdc_pkg::REG_DAMP_LIN: gain_lin = val;
            wsdc_pkg::REG_DAMP_ANG: gain_ang = val;
            wsdc_pkg::REG_STEP_F:   step_f = val[14:0];
            wsdc_pkg::REG_STEP_T:   step_t = val[14:0];
            wsdc_pkg::REG_MAX_F:    lim_f = val[14:0];
            wsdc_pkg::REG_MAX_T:    lim_t = val[14:0];
            default: ;
        endcase
    endtask

    task automatic set_all(logic [15:0] gl, logic [15:0] ga, logic [15:0] sf,
        logic [15:0] st, logic [15:0] mf, logic [15:0] mt);
        write_reg(wsdc_pkg::REG_DAMP_LIN, gl);
        write_reg(wsdc_pkg::REG_DAMP_ANG, ga);
        write_reg(wsdc_pkg::REG_STEP_F, sf);
        write_reg(wsdc_pkg::REG_STEP_T, st);
        write_reg(wsdc_pkg::REG_MAX_F, mf);
        write_reg(wsdc_pkg::REG_MAX_T, mt);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (wrench_queue.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Sends one item and queues its predicted result.
    task automatic send_item(wsdc_pkg::in_item_t it, logic known, wsdc_pkg::out_item_t want);
        wsdc_pkg::out_item_t p;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready && !timed_out)
            @(posedge clk);
        p = predict_wrench(it);
        if (known && p != want)
        begin
            $display("%0t predictor disagrees with table: expected %h got %h",
                $time, want, p);
            fails++;
        end
        wrench_queue = {wrench_queue, p};
        sent_items++;
    endtask

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(600)) - 16'sd300;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic wsdc_pkg::in_item_t random_item(wsdc_pkg::in_item_t prev);
        wsdc_pkg::in_item_t it;
        it = prev;
        if ($urandom_range(3) != 0)
        begin
            it.target_force_x = pick_value();
            it.target_force_y = pick_value();
            it.target_force_z = pick_value();
            it.target_torque_x = pick_value();
            it.target_torque_y = pick_value();
            it.target_torque_z = pick_value();
        end
        it.speed_x = pick_value();
        it.speed_y = pick_value();
        it.speed_z = pick_value();
        it.spin_x = pick_value();
        it.spin_y = pick_value();
        it.spin_z = pick_value();
        return it;
    endfunction

    task automatic random_phase(int count);
        wsdc_pkg::in_item_t it;
        wsdc_pkg::out_item_t none;
        none = '0;
        it = '0;
        for (int n = 0; n < count; n++)
        begin
            it = random_item(it);
            send_item(it, 1'b0, none);
        end
        drain_results();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_items++;
            if (wrench_queue.size() == 0)
            begin
                $display("%0t unexpected output transfer: expected none got %h",
                    $time, out_data);
                fails++;
            end
            else
            begin
                if (out_data.out_force_x !== wrench_queue[0].out_force_x
                    || out_data.out_force_y !== wrench_queue[0].out_force_y
                    || out_data.out_force_z !== wrench_queue[0].out_force_z
                    || out_data.out_torque_x !== wrench_queue[0].out_torque_x
                    || out_data.out_torque_y !== wrench_queue[0].out_torque_y
                    || out_data.out_torque_z !== wrench_queue[0].out_torque_z)
                begin
                    $display("%0t wrench mismatch: expected %h got %h",
                        $time, wrench_queue[0], out_data);
                    fails++;
                end
                void'(wrench_queue.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_recv)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count > STALL_LIM && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows [$];
        stim_row_t row;
        wsdc_pkg::in_item_t it;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_recv = 1'b0;
        timed_out = 1'b0;
        fails = 0;
        sent_items = 0;
        got_items = 0;
        idle_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        gain_lin = wsdc_pkg::RST_DAMP_LIN;
        gain_ang = wsdc_pkg::RST_DAMP_ANG;
        step_f = wsdc_pkg::RST_STEP_F;
        step_t = wsdc_pkg::RST_STEP_T;
        lim_f = wsdc_pkg::RST_MAX_F;
        lim_t = wsdc_pkg::RST_MAX_T;
        for (int i = 0; i < 6; i++)
            wrench_now[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero target from reset gives a zero wrench.
        row.item = '0; row.known = 1'b1; row.want = '0; rows = {rows, row};
        // A target exactly at the step magnitude moves without scaling.
        row.item = '0; row.item.target_force_x = 16'sd273;
        row.item.target_torque_y = -16'sd164;
        row.want = '0; row.want.out_force_x = 16'sd273; row.want.out_torque_y = -16'sd164;
        rows = {rows, row};
        row.known = 1'b0; row.want = '0;
        row.item = '0; row.item.target_force_x = 16'sh7FFF; row.item.target_torque_z = 16'sh8000;
        rows = {rows, row};
        row.item = '0; row.item.target_force_y = 16'sh8000; row.item.target_force_z = 16'sh7FFF;
        row.item.speed_x = 16'sh7FFF; row.item.spin_y = 16'sh8000;
        rows = {rows, row};
        row.item = '1; rows = {rows, row};
        row.item = {12{16'sh7FFF}}; rows = {rows, row};
        row.item = {12{16'sh8000}}; rows = {rows, row};
        row.item = '0; row.item.speed_y = 16'sh8000; row.item.spin_x = 16'sh7FFF;
        rows = {rows, row};

        send_idle_pct = 6;
        recv_idle_pct = 57;
        foreach (rows[i])
            send_item(rows[i].item, rows[i].known, rows[i].want);
        drain_results();

        // No step limit, no damping: the wrench jumps straight to the target, then clamps to the limits.
        set_all(16'd0, 16'd0, 16'd0, 16'd0, 16'h7FFF, 16'h7FFF);
        it = '0; it.target_force_x = 16'sh7FFF; it.target_force_y = 16'sh8000;
        it.target_torque_z = -16'sd5;
        row.want = '0; row.want.out_force_x = 16'sh7FFF; row.want.out_force_y = -16'sh7FFF;
        row.want.out_torque_z = -16'sd5;
        send_item(it, 1'b1, row.want);
        drain_results();
        // Zero limits force every axis to zero; oversized values keep the low bits.
        set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8001, 16'h8000, 16'h8000);
        it = {12{16'sh8000}};
        send_item(it, 1'b1, '0);
        drain_results();
        write_reg(IDX_SPARE_LO, 16'h1234);
        write_reg(IDX_SPARE_HI, 16'hFFFF);
        cfg_we <= 1'b0;
        drain_results();
        random_phase(150);

        set_all(wsdc_pkg::RST_DAMP_LIN, wsdc_pkg::RST_DAMP_ANG, 16'(wsdc_pkg::RST_STEP_F),
            16'(wsdc_pkg::RST_STEP_T), 16'(wsdc_pkg::RST_MAX_F), 16'(wsdc_pkg::RST_MAX_T));
        random_phase(350);

        send_idle_pct = 57;
        recv_idle_pct = 6;
        set_all(16'h7FFF, 16'd1, 16'd1, 16'h7FFF, 16'd1, 16'd100);
        random_phase(300);

        // Long receiver hold-off while the sender keeps offering items.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
        begin
            hold_recv = 1'b1;
            repeat (2000) @(posedge clk);
            hold_recv = 1'b0;
        end
        random_phase(20);
        join
        set_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom), 16'($urandom));
        random_phase(350);
        set_all(16'd0, 16'hFFFF, 16'd3000, 16'd0, 16'h7FFF, 16'd0);
        random_phase(350);

        $display("Covered %0d input and %0d output transfers over seven register settings,",
            sent_items, got_items);
        $display("including zero and full-scale steps, limits and gains.");
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
